FILE: src/imu_fall_motion_classifier_core_macros.svh
// Assertion helpers for the IMU classifier core.
`ifndef IMU_FALL_MOTION_CLASSIFIER_CORE_MACROS_SVH
`define IMU_FALL_MOTION_CLASSIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IFMC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define IFMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IFMC_ASSERT_IMPL(lbl, ante, cons)
`define IFMC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/ifmc_pkg.sv
`default_nettype none
package ifmc_pkg;

	localparam int unsigned ONE_G = 16384;
	localparam logic signed [29:0] DEG90_Z = 30'sd94371840;
	localparam logic signed [29:0] ROUND_HALF = 30'sd8192;
	localparam logic signed [18:0] TEMP_OFS = 19'sd62101;
	localparam logic [39:0] TEMP_RECIP = 40'd246724;

	localparam logic [15:0] GYRO_LIMIT_RST = 16'd23580;
	localparam logic [15:0] ACCEL_DEV_RST = 16'd9830;
	localparam logic [15:0] FALL_ACCEL_RST = 16'd36045;
	localparam logic [14:0] ANGLE_JUMP_RST = 15'd2240;

	localparam logic [1:0] REG_GYRO_LIMIT = 2'd0;
	localparam logic [1:0] REG_ACCEL_DEV = 2'd1;
	localparam logic [1:0] REG_FALL_ACCEL = 2'd2;
	localparam logic [1:0] REG_ANGLE_JUMP = 2'd3;

	localparam logic [1:0] STATUS_NORMAL = 2'd0;
	localparam logic [1:0] STATUS_FALL = 2'd1;
	localparam logic [1:0] STATUS_ABRUPT = 2'd2;

	localparam logic [1:0] SQ_ACCEL = 2'd0;
	localparam logic [1:0] SQ_GYRO = 2'd1;
	localparam logic [1:0] SQ_RADIUS = 2'd2;

	localparam logic [4:0] SQ_LAST = 5'd23;
	localparam logic [4:0] CO_LAST = 5'd19;
	localparam logic [4:0] MUL_LAST = 5'd9;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic       sq_load;
		logic       sq_step;
		logic       co_load;
		logic       co_step;
		logic       fin;
		logic [1:0] sel;
		logic [4:0] iter;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [26:0] atan_tab(input logic [4:0] i);
		logic [26:0] r;
		unique case (i)
			5'd0:  r = 27'd47185920;
			5'd1:  r = 27'd27855475;
			5'd2:  r = 27'd14718068;
			5'd3:  r = 27'd7471121;
			5'd4:  r = 27'd3750058;
			5'd5:  r = 27'd1876857;
			5'd6:  r = 27'd938658;
			5'd7:  r = 27'd469357;
			5'd8:  r = 27'd234682;
			5'd9:  r = 27'd117342;
			5'd10: r = 27'd58671;
			5'd11: r = 27'd29335;
			5'd12: r = 27'd14668;
			5'd13: r = 27'd7334;
			5'd14: r = 27'd3667;
			5'd15: r = 27'd1833;
			5'd16: r = 27'd917;
			5'd17: r = 27'd458;
			5'd18: r = 27'd229;
			5'd19: r = 27'd115;
			default: r = 27'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/ifmc_ctrl.sv
`default_nettype none
module ifmc_ctrl import ifmc_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_CO   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] pass_q, pass_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		pass_d = pass_q;
		cmd = '0;
		cmd.sel = pass_q;
		cmd.iter = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_MUL;
					cnt_d = '0;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (cnt_q == MUL_LAST) begin
					state_d = S_SQ;
					cnt_d = '0;
					pass_d = SQ_ACCEL;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_SQ: begin
				// Count zero loads the operand; the next 24 counts are root bits.
				cmd.iter = cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					cmd.sq_load = 1'b1;
					cnt_d = 5'd1;
				end else begin
					cmd.sq_step = 1'b1;
					if (cnt_q == SQ_LAST + 5'd1) begin
						cnt_d = '0;
						if (pass_q == SQ_RADIUS) begin
							state_d = S_CO;
							pass_d = '0;
						end else begin
							pass_d = pass_q + 2'd1;
						end
					end else begin
						cnt_d = cnt_q + 5'd1;
					end
				end
			end
			S_CO: begin
				cmd.iter = cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					cmd.co_load = 1'b1;
					cnt_d = 5'd1;
				end else begin
					cmd.co_step = 1'b1;
					if (cnt_q == CO_LAST + 5'd1) begin
						cnt_d = '0;
						if (pass_q == 2'd1) begin
							state_d = S_FIN;
						end else begin
							pass_d = pass_q + 2'd1;
						end
					end else begin
						cnt_d = cnt_q + 5'd1;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pass_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			pass_q <= pass_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/ifmc_dp.sv
`default_nettype none
module ifmc_dp import ifmc_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  wire  [111:0] s_tdata,
	input  wire          cfg_we,
	input  wire  [1:0]   cfg_addr,
	input  wire  [15:0]  cfg_wdata,
	input  wire          m_tready,
	output logic         m_tvalid,
	output logic [79:0]  m_tdata
);

	logic [15:0] gl_q, dev_q, fl_q;
	logic [14:0] ajl_q;

	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic signed [14:0] temp_q;

	logic [30:0] ax2_q;
	logic [31:0] yz2_q, a2_q, g2_q, gl2_q, fl2_q;
	logic [32:0] up2_q;
	logic [28:0] lo2_q;

	logic [47:0] sq_v_q;
	logic [25:0] sq_rem_q;
	logic [23:0] sq_root_q;
	logic [15:0] amag_q, gmag_q;
	logic [23:0] rad_q;

	logic signed [27:0] cx_q, cy_q;
	logic signed [29:0] cz_q;
	logic               spec_q;
	logic signed [15:0] specv_q;
	logic signed [14:0] roll_q, prev_roll_q;
	logic signed [13:0] pitch_q, prev_pitch_q;
	logic               first_q;
	logic               m_tvalid_q;

	// Temperature: (5*t + 62101)/17 toward zero, by reciprocal on the magnitude.
	logic signed [15:0] traw;
	logic signed [18:0] tn;
	logic [17:0] tmag;
	logic [39:0] tprod;
	logic [14:0] tq;
	assign traw = s_tdata[111:96];
	assign tn = 19'(traw) * 19'sd5 + TEMP_OFS;
	assign tmag = tn[18] ? 18'(-tn) : tn[17:0];
	assign tprod = {22'd0, tmag} * TEMP_RECIP;
	assign tq = tprod[36:22];

	// Shared squaring multiplier.
	logic signed [17:0] opd;
	logic signed [35:0] prod;
	always_comb begin
		unique case (cmd.iter[3:0])
			4'd0: opd = 18'(ax_q);
			4'd1: opd = 18'(ay_q);
			4'd2: opd = 18'(az_q);
			4'd3: opd = 18'(gx_q);
			4'd4: opd = 18'(gy_q);
			4'd5: opd = 18'(gz_q);
			4'd6: opd = {2'b00, gl_q};
			4'd7: opd = 18'(17'(ONE_G) + {1'b0, dev_q});
			4'd8: opd = 18'(17'(ONE_G) - {1'b0, dev_q});
			4'd9: opd = {2'b00, fl_q};
			default: opd = '0;
		endcase
	end
	assign prod = opd * opd;

	// Square root, one result bit per step.
	logic [25:0] remn, trial;
	logic        ge;
	logic [23:0] rootn;
	assign remn = {sq_rem_q[23:0], sq_v_q[47:46]};
	assign trial = {sq_root_q, 2'b01};
	assign ge = (remn >= trial);
	assign rootn = {sq_root_q[22:0], ge};

	// CORDIC vectoring.
	logic signed [27:0] y0, x0, dx, dy, cxn, cyn;
	logic signed [29:0] at, czn, zr;
	logic signed [15:0] ang, angv, lim, clamped;
	always_comb begin
		if (cmd.sel == 2'd0) begin
			y0 = {{4{ay_q[15]}}, ay_q, 8'd0};
			x0 = {{4{az_q[15]}}, az_q, 8'd0};
		end else begin
			y0 = 28'sd0 - {{4{ax_q[15]}}, ax_q, 8'd0};
			x0 = {4'd0, rad_q};
		end
	end
	assign dx = cy_q >>> cmd.iter;
	assign dy = cx_q >>> cmd.iter;
	assign at = 30'(atan_tab(cmd.iter));
	assign cxn = cy_q[27] ? cx_q - dx : cx_q + dx;
	assign cyn = cy_q[27] ? cy_q + dy : cy_q - dy;
	assign czn = cy_q[27] ? cz_q - at : cz_q + at;
	assign zr = czn + ROUND_HALF;
	assign ang = zr[29:14];
	assign angv = spec_q ? specv_q : ang;
	assign lim = (cmd.sel == 2'd0) ? 16'sd11520 : 16'sd5760;
	always_comb begin
		if (angv > lim) clamped = lim;
		else if (angv < -lim) clamped = -lim;
		else clamped = angv;
	end

	// Classification.
	logic signed [15:0] dr, dp;
	logic [15:0] adr, adp;
	logic fall, abrupt;
	logic [1:0] status;
	assign dr = 16'(roll_q) - 16'(prev_roll_q);
	assign dp = 16'(pitch_q) - 16'(prev_pitch_q);
	assign adr = first_q ? 16'd0 : (dr[15] ? 16'(-dr) : dr);
	assign adp = first_q ? 16'd0 : (dp[15] ? 16'(-dp) : dp);
	assign fall = (a2_q > fl2_q) && ((adr > {1'b0, ajl_q}) || (adp > {1'b0, ajl_q}));
	assign abrupt = (g2_q > gl2_q) || ({1'b0, a2_q} > up2_q) ||
		((dev_q < 16'(ONE_G)) && (a2_q < {3'd0, lo2_q}));
	always_comb begin
		priority if (fall) status = STATUS_FALL;
		else if (abrupt) status = STATUS_ABRUPT;
		else status = STATUS_NORMAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gl_q <= GYRO_LIMIT_RST;
			dev_q <= ACCEL_DEV_RST;
			fl_q <= FALL_ACCEL_RST;
			ajl_q <= ANGLE_JUMP_RST;
			prev_roll_q <= '0;
			prev_pitch_q <= '0;
			first_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_GYRO_LIMIT: gl_q <= cfg_wdata;
					REG_ACCEL_DEV:  dev_q <= cfg_wdata;
					REG_FALL_ACCEL: fl_q <= cfg_wdata;
					REG_ANGLE_JUMP: ajl_q <= cfg_wdata[14:0];
					default: ;
				endcase
			end
			if (cmd.fin) begin
				prev_roll_q <= roll_q;
				prev_pitch_q <= pitch_q;
				first_q <= 1'b0;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= s_tdata[15:0];
			ay_q <= s_tdata[31:16];
			az_q <= s_tdata[47:32];
			gx_q <= s_tdata[63:48];
			gy_q <= s_tdata[79:64];
			gz_q <= s_tdata[95:80];
			temp_q <= tn[18] ? 15'(15'd0 - tq) : tq;
		end
		if (cmd.mul_en) begin
			unique case (cmd.iter[3:0])
				4'd0: ax2_q <= prod[30:0];
				4'd1: yz2_q <= prod[31:0];
				4'd2: yz2_q <= yz2_q + prod[31:0];
				4'd3: g2_q <= prod[31:0];
				4'd4: g2_q <= g2_q + prod[31:0];
				4'd5: g2_q <= g2_q + prod[31:0];
				4'd6: gl2_q <= prod[31:0];
				4'd7: up2_q <= prod[32:0];
				4'd8: lo2_q <= prod[28:0];
				4'd9: begin
					fl2_q <= prod[31:0];
					a2_q <= yz2_q + {1'b0, ax2_q};
				end
				default: ;
			endcase
		end
		if (cmd.sq_load) begin
			unique case (cmd.sel)
				SQ_ACCEL: sq_v_q <= {a2_q, 16'd0};
				SQ_GYRO:  sq_v_q <= {g2_q, 16'd0};
				default:  sq_v_q <= {yz2_q, 16'd0};
			endcase
			sq_rem_q <= '0;
			sq_root_q <= '0;
		end
		if (cmd.sq_step) begin
			sq_v_q <= {sq_v_q[45:0], 2'b00};
			sq_rem_q <= ge ? remn - trial : remn;
			sq_root_q <= rootn;
			if (cmd.iter == SQ_LAST) begin
				unique case (cmd.sel)
					SQ_ACCEL: amag_q <= rootn[23:8];
					SQ_GYRO:  gmag_q <= rootn[23:8];
					default:  rad_q <= rootn;
				endcase
			end
		end
		if (cmd.co_load) begin
			spec_q <= (y0 == 28'sd0) || (x0 == 28'sd0);
			if (y0 == 28'sd0) specv_q <= x0[27] ? 16'sd11520 : 16'sd0;
			else specv_q <= y0[27] ? -16'sd5760 : 16'sd5760;
			if (x0[27]) begin
				// Rotate into the right half plane by a quarter turn first.
				if (!y0[27]) begin
					cx_q <= y0;
					cy_q <= -x0;
					cz_q <= DEG90_Z;
				end else begin
					cx_q <= -y0;
					cy_q <= x0;
					cz_q <= -DEG90_Z;
				end
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end
		if (cmd.co_step) begin
			cx_q <= cxn;
			cy_q <= cyn;
			cz_q <= czn;
			if (cmd.iter == CO_LAST) begin
				if (cmd.sel == 2'd0) roll_q <= clamped[14:0];
				else pitch_q <= clamped[13:0];
			end
		end
		if (cmd.fin) begin
			m_tdata <= {2'b00, status, temp_q, pitch_q, roll_q, gmag_q, amag_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule
`default_nettype wire

FILE: src/imu_fall_motion_classifier_core.sv
// IMU fall and abrupt-motion classifier.
// Input stream s_*: one word per six-axis sample plus raw die temperature.
// Output stream m_*: one word per sample with the accel and gyro magnitudes,
// roll and pitch in 1/64 degree, temperature in hundredths of a degree and
// the status code (normal, possible fall, abrupt movement).
// cfg_we/cfg_addr/cfg_wdata write the four limit registers; write them only
// while the block is idle.
// Each sample runs through a shared squaring multiplier, three 24-step
// square roots sharing one unit, two 20-step CORDIC passes and a final step
// that places the word in the output register. The next sample is accepted
// in the cycle after that final step, not before.
// The output register holds a finished word while the receiver stalls; a
// new sample is processed meanwhile and waits at its last step until the
// register frees up.
// Reset clears the handshake state, restores the limit defaults, zeroes the
// previous angles and marks the next sample as the first one.
`default_nettype none
`include "imu_fall_motion_classifier_core_macros.svh"
module imu_fall_motion_classifier_core import ifmc_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, die temperature
	input  wire [111:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// accel norm, gyro norm, roll_angle, pitch_angle, temp_centi, status, zero fill
	output logic [79:0] m_tdata,
	input  wire         cfg_we,
	input  wire [1:0]   cfg_addr,
	input  wire [15:0]  cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	ifmc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	ifmc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.s_tdata(s_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata(m_tdata)
	);

	`IFMC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`IFMC_ASSERT_IMPL(a_fin_needs_room, cmd.fin, sts.out_free)
	`IFMC_ASSERT_IMPL(a_one_op, 1'b1,
		$onehot0({cmd.load, cmd.mul_en, cmd.sq_load, cmd.sq_step,
			cmd.co_load, cmd.co_step, cmd.fin}))

endmodule
`default_nettype wire
